FILE: src/pose_to_grid_cell_index_macros.svh
// assertion helpers for pose_to_grid_cell_index
`ifndef POSE_TO_GRID_CELL_INDEX_MACROS_SVH
`define POSE_TO_GRID_CELL_INDEX_MACROS_SVH

// same-cycle implication, checked on the rising edge of clk
`define PGCI_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGCI_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pgci_pkg.sv
// ----------------------------------------------------------------------------
// pgci_pkg
// shared widths, constants and the arctangent table of the grid index block
// ----------------------------------------------------------------------------
`default_nettype none

package pgci_pkg;

    localparam int NUM_W     = 33;  // signed sum / heading width into the dividers
    localparam int MAG_W     = 32;  // magnitude width inside the dividers
    localparam int STEP_W    = 31;
    localparam int ROW_W     = 16;
    localparam int MARGIN_W  = 16;
    localparam int CORD_W    = 28;  // cordic x / y
    localparam int ANG_W     = 21;  // cordic angle, signed q4.16 radians
    localparam int ATAN_W    = 17;
    localparam int PRESCALE  = 8;
    localparam int ATAN_N    = 24;
    localparam int DIV_LAT   = MAG_W + 2;

    localparam int DEF_MARGIN_XY    = 6554;
    localparam int DEF_MARGIN_YAW   = 5719;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam logic signed [ANG_W-1:0] PI_Q16 = 21'sd205887;

    typedef enum logic [3:0] {
        REG_OFFSET_X   = 4'd0,
        REG_OFFSET_Y   = 4'd1,
        REG_STEP_X     = 4'd2,
        REG_STEP_Y     = 4'd3,
        REG_STEP_YAW   = 4'd4,
        REG_ROW_LENGTH = 4'd5,
        REG_PLANE_SIZE = 4'd6,
        REG_ENABLED    = 4'd7
    } cfg_reg_t;

    function automatic logic [ATAN_W-1:0] atan_q16(input int i);
        logic [ATAN_W-1:0] v;
        case (i)
            0:       v = 17'd51472;
            1:       v = 17'd30386;
            2:       v = 17'd16055;
            3:       v = 17'd8150;
            4:       v = 17'd4091;
            5:       v = 17'd2047;
            6:       v = 17'd1024;
            7:       v = 17'd512;
            8:       v = 17'd256;
            9:       v = 17'd128;
            10:      v = 17'd64;
            11:      v = 17'd32;
            12:      v = 17'd16;
            13:      v = 17'd8;
            14:      v = 17'd4;
            15:      v = 17'd2;
            16:      v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/pose_to_grid_cell_index.sv
// an accepted input word runs through the input register, cordic, dividers and tail to its result word
// throughput: one word per cycle; every stage holds while the output word is stalled
// the depth is set by the cordic stages plus one stage per quotient bit in the dividers
// reset: rst_n is asynchronous, clears valid bits and config registers to their defaults
// ----------------------------------------------------------------------------
// pose_to_grid_cell_index
// maps a 2d pose onto x, y and heading cells of a grid table and its linear index
// ----------------------------------------------------------------------------
`default_nettype none

`include "pose_to_grid_cell_index_macros.svh"

module pose_to_grid_cell_index #(
    parameter int MARGIN_XY    = pgci_pkg::DEF_MARGIN_XY,
    parameter int MARGIN_YAW   = pgci_pkg::DEF_MARGIN_YAW,
    parameter int CORDIC_STEPS = pgci_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    // pose words in
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [15:0] rot_cos,
    input  wire logic signed [15:0] rot_sin,
    // cell words out
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      cell_x,
    output logic signed [31:0]      cell_y,
    output logic signed [31:0]      cell_yaw,
    output logic signed [31:0]      cell_index,
    output logic                    in_range,
    output logic                    valid_res
);
    import pgci_pkg::*;

    localparam int N   = CORDIC_STEPS;
    localparam int LAT = N + DIV_LAT + 4;   // input reg + cordic + divider + 3 tail stages
    localparam logic [MARGIN_W-1:0] M_XY  = MARGIN_W'(MARGIN_XY);
    localparam logic [MARGIN_W-1:0] M_YAW = MARGIN_W'(MARGIN_YAW);

    // ---------------- configuration registers ----------------
    logic signed [31:0]  off_x_reg, off_y_reg;
    logic [STEP_W-1:0]   step_x_reg, step_y_reg, step_yaw_reg, plane_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                en_reg;

    // no write is taken while reset is held
    assign cfg_ready = rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg    <= '0;
            off_y_reg    <= '0;
            step_x_reg   <= STEP_W'(65536);
            step_y_reg   <= STEP_W'(65536);
            step_yaw_reg <= STEP_W'(65536);
            row_reg      <= ROW_W'(1);
            plane_reg    <= STEP_W'(1);
            en_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OFFSET_X:   off_x_reg    <= $signed(cfg_data);
                REG_OFFSET_Y:   off_y_reg    <= $signed(cfg_data);
                REG_STEP_X:     step_x_reg   <= cfg_data[STEP_W-1:0];
                REG_STEP_Y:     step_y_reg   <= cfg_data[STEP_W-1:0];
                REG_STEP_YAW:   step_yaw_reg <= cfg_data[STEP_W-1:0];
                REG_ROW_LENGTH: row_reg      <= cfg_data[ROW_W-1:0];
                REG_PLANE_SIZE: plane_reg    <= cfg_data[STEP_W-1:0];
                REG_ENABLED:    en_reg       <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // a step written as zero behaves as one
    logic [STEP_W-1:0] st_x, st_y, st_w;
    assign st_x = (step_x_reg   == '0) ? STEP_W'(1) : step_x_reg;
    assign st_y = (step_y_reg   == '0) ? STEP_W'(1) : step_y_reg;
    assign st_w = (step_yaw_reg == '0) ? STEP_W'(1) : step_yaw_reg;

    // ---------------- pipeline control ----------------
    // all stages move together; a stalled output word freezes the whole line
    logic vld_reg [0:LAT-1];
    logic adv;

    assign adv      = !vld_reg[LAT-1] || out_ready;
    assign in_ready = adv && rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- input stage: offsets and half-turn pre-rotation ----------------
    logic signed [NUM_W-1:0]  px_reg [0:N];
    logic signed [NUM_W-1:0]  py_reg [0:N];
    logic signed [CORD_W-1:0] cx_reg [0:N];
    logic signed [CORD_W-1:0] cy_reg [0:N];
    logic signed [ANG_W-1:0]  z_reg  [0:N];

    logic signed [CORD_W-1:0] c_in, s_in;
    assign c_in = CORD_W'(rot_cos) <<< PRESCALE;
    assign s_in = CORD_W'(rot_sin) <<< PRESCALE;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg[0] <= NUM_W'(pos_x) + NUM_W'(off_x_reg);
            py_reg[0] <= NUM_W'(pos_y) + NUM_W'(off_y_reg);
            if (rot_cos < 0)
            begin
                cx_reg[0] <= -c_in;
                cy_reg[0] <= -s_in;
                z_reg[0]  <= (rot_sin >= 0) ? PI_Q16 : -PI_Q16;
            end
            else
            begin
                cx_reg[0] <= c_in;
                cy_reg[0] <= s_in;
                z_reg[0]  <= '0;
            end
        end
    end

    // ---------------- cordic vectoring, one iteration a stage ----------------
    for (genvar k = 0; k < N; k++)
    begin : g_cordic
        localparam logic signed [ANG_W-1:0] ATAN_K = ANG_W'(atan_q16(k));
        logic signed [CORD_W-1:0] dx, dy;
        assign dx = cy_reg[k] >>> k;
        assign dy = cx_reg[k] >>> k;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                px_reg[k+1] <= px_reg[k];
                py_reg[k+1] <= py_reg[k];
                if (cy_reg[k] > 0)
                begin
                    cx_reg[k+1] <= cx_reg[k] + dx;
                    cy_reg[k+1] <= cy_reg[k] - dy;
                    z_reg[k+1]  <= z_reg[k] + ATAN_K;
                end
                else if (cy_reg[k] < 0)
                begin
                    cx_reg[k+1] <= cx_reg[k] - dx;
                    cy_reg[k+1] <= cy_reg[k] + dy;
                    z_reg[k+1]  <= z_reg[k] - ATAN_K;
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k];
                    cy_reg[k+1] <= cy_reg[k];
                    z_reg[k+1]  <= z_reg[k];
                end
            end
        end
    end

    // heading shifted into [0, 2pi]
    logic signed [NUM_W-1:0] yaw;
    assign yaw = NUM_W'(z_reg[N]) + NUM_W'(PI_Q16);

    // ---------------- floor dividers ----------------
    logic signed [NUM_W-1:0] qx, qy, qw;
    logic [STEP_W-1:0]       rx, ry, rw;

    pgci_div u_div_x (.clk(clk), .en(adv), .num(px_reg[N]), .den(st_x), .quo(qx), .rem(rx));
    pgci_div u_div_y (.clk(clk), .en(adv), .num(py_reg[N]), .den(st_y), .quo(qy), .rem(ry));
    pgci_div u_div_w (.clk(clk), .en(adv), .num(yaw),       .den(st_w), .quo(qw), .rem(rw));

    function automatic logic [31:0] sat32(input logic signed [NUM_W-1:0] v);
        logic [31:0] r;
        if (v[NUM_W-1] != v[NUM_W-2])
        begin
            r = v[NUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic inside_cell(input logic [STEP_W-1:0] r,
                                         input logic [STEP_W-1:0] st,
                                         input logic [MARGIN_W-1:0] m);
        logic [STEP_W:0] hi;
        hi = {1'b0, r} + (STEP_W+1)'(m);
        return ({1'b0, r} > (STEP_W+1)'(m)) && (hi < {1'b0, st});
    endfunction

    // ---------------- tail: saturate and margins ----------------
    logic [31:0] sx_reg, sy_reg, sw_reg;
    logic        ok_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg   <= sat32(qx);
            sy_reg   <= sat32(qy);
            sw_reg   <= sat32(qw);
            ok_a_reg <= inside_cell(rx, st_x, M_XY) && inside_cell(ry, st_y, M_XY)
                        && inside_cell(rw, st_w, M_YAW);
        end
    end

    // ---------------- tail: products, low 32 bits only ----------------
    logic [31:0] tx_reg, ty_reg, tw_reg, pw_reg, py2_reg;
    logic        ok_b_reg;
    logic [63:0] prod_w;
    logic [47:0] prod_y;

    assign prod_w = sw_reg * {1'b0, plane_reg};
    assign prod_y = sy_reg * row_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx_reg   <= sx_reg;
            ty_reg   <= sy_reg;
            tw_reg   <= sw_reg;
            pw_reg   <= prod_w[31:0];
            py2_reg  <= prod_y[31:0];
            ok_b_reg <= ok_a_reg;
        end
    end

    // ---------------- output word ----------------
    logic [31:0] ox_reg, oy_reg, ow_reg, oi_reg;
    logic        or_reg, ov_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (en_reg)
            begin
                ox_reg <= tx_reg;
                oy_reg <= ty_reg;
                ow_reg <= tw_reg;
                oi_reg <= pw_reg + py2_reg + tx_reg;
                or_reg <= ok_b_reg;
                ov_reg <= 1'b1;
            end
            else
            begin
                ox_reg <= '0;
                oy_reg <= '0;
                ow_reg <= '0;
                oi_reg <= '1;
                or_reg <= 1'b0;
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = vld_reg[LAT-1];
    assign cell_x     = $signed(ox_reg);
    assign cell_y     = $signed(oy_reg);
    assign cell_yaw   = $signed(ow_reg);
    assign cell_index = $signed(oi_reg);
    assign in_range   = or_reg;
    assign valid_res  = ov_reg;

    // ---------------- checks ----------------
    `PGCI_ASSERT_IMP(a_flag_needs_valid, out_valid && in_range, valid_res,
        "in_range set on a disabled result")
    `PGCI_ASSERT_IMP(a_disabled_index, out_valid && !valid_res, cell_index == -32'sd1,
        "disabled result without index of minus one")
    `PGCI_ASSERT_NXT(a_valid_moves, vld_reg[0] && adv, vld_reg[1],
        "valid bit lost between first stages")

endmodule

`default_nettype wire

FILE: src/pgci_div.sv
// ----------------------------------------------------------------------------
// pgci_div
// pipelined floor division of a signed value by a positive step, one bit a stage
// ----------------------------------------------------------------------------
`default_nettype none

module pgci_div (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [pgci_pkg::NUM_W-1:0]   num,
    input  wire logic        [pgci_pkg::STEP_W-1:0]  den,
    output logic signed      [pgci_pkg::NUM_W-1:0]   quo,
    output logic             [pgci_pkg::STEP_W-1:0]  rem
);
    import pgci_pkg::*;

    logic [MAG_W-1:0]  work_reg [0:MAG_W];
    logic [STEP_W-1:0] rem_reg  [0:MAG_W];
    logic              neg_reg  [0:MAG_W];
    logic [MAG_W-1:0]  mag;

    logic signed [NUM_W-1:0] quo_reg;
    logic [STEP_W-1:0]       remo_reg;

    // negative values fold onto -v-1 so one unsigned divider serves both signs
    assign mag = num[NUM_W-1] ? ~num[MAG_W-1:0] : num[MAG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg[0] <= mag;
            rem_reg[0]  <= '0;
            neg_reg[0]  <= num[NUM_W-1];
        end
    end

    for (genvar k = 0; k < MAG_W; k++)
    begin : g_stage
        logic [STEP_W:0]   trial;
        logic              fit;
        logic [STEP_W-1:0] rem_next;
        assign trial    = {rem_reg[k], work_reg[k][MAG_W-1]};
        assign fit      = (trial >= {1'b0, den});
        assign rem_next = fit ? STEP_W'(trial - {1'b0, den}) : trial[STEP_W-1:0];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[k+1] <= {work_reg[k][MAG_W-2:0], fit};
                rem_reg[k+1]  <= rem_next;
                neg_reg[k+1]  <= neg_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[MAG_W])
            begin
                quo_reg  <= ~$signed({1'b0, work_reg[MAG_W]});
                remo_reg <= den - STEP_W'(1) - rem_reg[MAG_W];
            end
            else
            begin
                quo_reg  <= $signed({1'b0, work_reg[MAG_W]});
                remo_reg <= rem_reg[MAG_W];
            end
        end
    end

    assign quo = quo_reg;
    assign rem = remo_reg;

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// pose words with random gaps and output stalls, each result word checked
// against a local model of offset, cordic heading and floor division
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import pgci_pkg::*;

    localparam int LATENCY   = DEF_CORDIC_STEPS + 38;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1900;
    localparam int CALM_TAIL = 200;   // last words run with no idling
    localparam int N_PHASES  = 5;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] yaw;
        logic signed [31:0] idx;
        logic               ok;
        logic               vld;
    } cell_word_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic               typed;  // expected word typed in the row
        cell_word_t         want;
    } pose_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [15:0] rot_cos = '0;
    logic signed [15:0] rot_sin = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] cell_x, cell_y, cell_yaw, cell_index;
    logic               in_range, valid_res;

    pose_to_grid_cell_index i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .rot_cos(rot_cos), .rot_sin(rot_sin),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_x(cell_x), .cell_y(cell_y), .cell_yaw(cell_yaw),
        .cell_index(cell_index), .in_range(in_range), .valid_res(valid_res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // model copy of the register file
    logic signed [31:0] m_off_x, m_off_y;
    logic [30:0]        m_step_x, m_step_y, m_step_yaw, m_plane;
    logic [15:0]        m_row;
    logic               m_en;

    cell_word_t expected_cells[$];
    int  n_fail = 0;
    int  n_mism = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  stim_done = 1'b0;

    function automatic longint atan_entry(input int i);
        longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? t[i] : 0;
    endfunction

    // cordic heading plus pi, shifts are arithmetic
    function automatic longint heading_plus_pi(input longint c, input longint s);
        longint hx, hy, hz, dx, dy;
        hx = c * 256;
        hy = s * 256;
        hz = 0;
        if (c < 0)
        begin
            hx = -hx;
            hy = -hy;
            hz = (s >= 0) ? 205887 : -205887;
        end
        for (int i = 0; i < DEF_CORDIC_STEPS; i++)
        begin
            dx = hy >>> i;
            dy = hx >>> i;
            if (hy > 0)
            begin
                hx += dx; hy -= dy; hz += atan_entry(i);
            end
            else if (hy < 0)
            begin
                hx -= dx; hy += dy; hz -= atan_entry(i);
            end
        end
        return hz + 205887;
    endfunction

    // floor quotient saturated to 32 bits, margin check on the remainder
    function automatic logic [31:0] floor_cell(input longint v, input logic [30:0] step,
                                               input longint margin, inout logic ok);
        longint st, q, r;
        st = (step == 0) ? 1 : longint'(step);
        q = v / st;
        if ((v % st) != 0 && v < 0)
            q--;
        r = v - q * st;
        if (!(r > margin && r < st - margin))
            ok = 1'b0;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic cell_word_t predict_cells(input logic signed [31:0] px,
                                                 input logic signed [31:0] py,
                                                 input logic signed [15:0] c,
                                                 input logic signed [15:0] s);
        cell_word_t w;
        logic ok;
        ok = 1'b1;
        if (!m_en)
        begin
            w = '0;
            w.idx = -32'sd1;
            return w;
        end
        w.x   = floor_cell(longint'(px) + m_off_x, m_step_x, DEF_MARGIN_XY, ok);
        w.y   = floor_cell(longint'(py) + m_off_y, m_step_y, DEF_MARGIN_XY, ok);
        w.yaw = floor_cell(heading_plus_pi(c, s), m_step_yaw, DEF_MARGIN_YAW, ok);
        w.idx = w.yaw * {1'b0, m_plane} + w.y * {16'd0, m_row} + w.x;
        w.ok  = ok;
        w.vld = 1'b1;
        return w;
    endfunction

    // result side: compare every accepted word against the oldest expectation
    always @(posedge clk)
    begin
        cell_word_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{cell_x, cell_y, cell_yaw, cell_index, in_range, valid_res};
            if (expected_cells.size() == 0)
            begin
                n_fail++;
                if (n_mism++ < 10)
                    $display("unexpected word: %p", got);
            end
            else
            begin
                want = expected_cells.pop_front();
                if (got !== want)
                begin
                    n_fail++;
                    if (n_mism++ < 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // result side stalls in bursts
    always @(negedge clk)
    begin
        if (calm || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clk);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || (stim_done && expected_cells.size() == 0))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // called at a falling edge; returns at the next falling edge after the write is dropped
    task automatic write_reg(input cfg_reg_t r, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (r)
            REG_OFFSET_X:   m_off_x = d;
            REG_OFFSET_Y:   m_off_y = d;
            REG_STEP_X:     m_step_x = d[30:0];
            REG_STEP_Y:     m_step_y = d[30:0];
            REG_STEP_YAW:   m_step_yaw = d[30:0];
            REG_ROW_LENGTH: m_row = d[15:0];
            REG_PLANE_SIZE: m_plane = d[30:0];
            REG_ENABLED:    m_en = d[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // called at a falling edge; leaves valid high, a gap or drain lowers it
    task automatic send_pose(input pose_row_t row);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= row.px;
        pos_y    <= row.py;
        rot_cos  <= row.c;
        rot_sin  <= row.s;
        expected_cells.insert(expected_cells.size(),
                              row.typed ? row.want
                                        : predict_cells(row.px, row.py, row.c, row.s));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // called at the falling edge right after the last accepted word
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'h7FFF_FFFF;
            3: return $urandom_range(6554 * 2 - 10, 6554 * 2 + 10);
            default: return $urandom_range(1000, 300000);
        endcase
    endfunction

    function automatic pose_row_t random_pose();
        pose_row_t r;
        r.typed = 1'b0;
        r.want  = '0;
        r.px = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 2000000)) - 1000000;
        r.py = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 2000000)) - 1000000;
        case ($urandom_range(0, 5))
            0: begin r.c = $urandom(); r.s = $urandom(); end
            1: begin r.c = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF; r.s = 0; end
            2: begin r.c = 0; r.s = $urandom_range(0, 1) ? -16'sd16384 : 16'sd16384; end
            default:
            begin
                // components in [-1, 1] in q2.14
                r.c = $signed($urandom_range(0, 32768)) - 16384;
                r.s = $signed($urandom_range(0, 32768)) - 16384;
            end
        endcase
        return r;
    endfunction

    pose_row_t directed[] = '{
        // not enabled after reset: all zero and index of minus one
        '{32'sd0, 32'sd0, 16'sd16384, 16'sd0, 1'b1, '{0, 0, 0, -1, 1'b0, 1'b0}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 16'sh7FFF, 16'sh8000, 1'b1,
          '{0, 0, 0, -1, 1'b0, 1'b0}},
        // rows below are predicted once the block is enabled
        '{32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0, '0},            // zero vector
        '{32'sd32768, 32'sd32768, -16'sd16384, 16'sd0, 1'b0, '0}, // negative x axis
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
        '{32'h8000_0000, 32'h8000_0000, 16'sh8000, 16'sh8000, 1'b0, '0},
        '{32'sd6554, 32'sd6555, 16'sd0, 16'sd16384, 1'b0, '0},
        '{-32'sd1, -32'sd65536, 16'sd0, -16'sd16384, 1'b0, '0},
        '{32'sd100000, -32'sd100000, 16'sd11585, 16'sd11585, 1'b0, '0},
        '{-32'sd5, 32'sd58982, -16'sd11585, -16'sd11585, 1'b0, '0},
        '{32'sd0, 32'sd0, -16'sd1, 16'sd0, 1'b0, '0},
        '{32'sd0, 32'sd0, -16'sd1, -16'sd1, 1'b0, '0}
    };

    initial
    begin
        m_off_x = 0; m_off_y = 0;
        m_step_x = 65536; m_step_y = 65536; m_step_yaw = 65536;
        m_row = 1; m_plane = 1; m_en = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (i == 2)
            begin
                drain();
                write_reg(REG_ENABLED, 32'd1);
            end
            send_pose(directed[i]);
        end
        drain();

        // bad register index is ignored, values masked to register width
        write_reg(cfg_reg_t'(4'd9), 32'hFFFF_FFFF);
        write_reg(REG_ROW_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_PLANE_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_OFFSET_X, 32'h7FFF_FFFF);
        write_reg(REG_OFFSET_Y, 32'h8000_0000);
        for (int k = 0; k < 20; k++)
            send_pose(random_pose());
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_reg(REG_OFFSET_X, (ph == 1) ? 32'h8000_0000 : $urandom_range(0, 4000000) - 2000000);
            write_reg(REG_OFFSET_Y, (ph == 1) ? 32'h7FFF_FFFF : $urandom_range(0, 4000000) - 2000000);
            write_reg(REG_STEP_X, pick_step());
            write_reg(REG_STEP_Y, pick_step());
            write_reg(REG_STEP_YAW, (ph == 0) ? 32'd20000 : pick_step());
            write_reg(REG_ROW_LENGTH, (ph == 2) ? 32'd1 : $urandom_range(1, 65535));
            write_reg(REG_PLANE_SIZE, (ph == 2) ? 32'd0 : $urandom());
            write_reg(REG_ENABLED, (ph == 3) ? 32'd0 : 32'd1);
            for (int k = 0; k < N_RANDOM / N_PHASES; k++)
            begin
                calm = (ph == N_PHASES - 1) && (k >= N_RANDOM / N_PHASES - CALM_TAIL);
                send_pose(random_pose());
            end
            drain();
        end

        stim_done = 1'b1;
        if (n_fail == 0 && expected_cells.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/pgci_pkg.sv
src/pgci_div.sv
src/pose_to_grid_cell_index.sv
bench/tb.sv
